[hw/rtl/lpra_pkg.sv]
// ============================================================================
// Log pack record allocator package
// Field widths, configuration register indexes, controller state and result
// codes, and the command and status bundles between controller and datapath.
// ============================================================================
package lpra_pkg;

    localparam int POS_W    = 64;
    localparam int OFFSET_W = 64;
    localparam int SIZE_W   = 32;
    localparam int SHIFT_W  = 2;
    localparam int COUNT_W  = 8;
    localparam int BLOCKS_W = 16;
    localparam int LOCAL_W  = 16;
    localparam int BPB_W    = SIZE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_CNT_W  = $clog2(POS_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE_BLOCKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL_BLOCKS = 2'd3;

    localparam logic [SHIFT_W-1:0]    RST_BLOCK_SHIFT      = '0;
    localparam logic [COUNT_W-1:0]    RST_MAX_RECORDS      = 8'd15;
    localparam logic [POS_W-1:0]      RST_RING_SIZE_BLOCKS = 64'd65536;
    localparam logic [BLOCKS_W-1:0]   RST_MAX_TOTAL_BLOCKS = 16'd65535;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_PAD_CALC,
        S_PAD_CHECK,
        S_EMIT_PAD,
        S_BUDGET,
        S_EMIT_LAST
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RES_BEGIN,
        RES_ACK,
        RES_REFUSE,
        RES_PAD,
        RES_RECORD
    } res_kind_t;

    typedef struct packed {
        logic      in_ready;
        logic      div_start;
        logic      div_step;
        logic      pad_load;
        logic      emit;
        res_kind_t kind;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic op_add;
        logic table_full;
        logic size_zero;
        logic use_ring;
        logic div_done;
        logic pad_fits;
        logic pad_over_budget;
        logic rec_over_budget;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/lpra_in_if.sv]
// ============================================================================
// Request channel
// Valid/ready channel that carries one begin or add request per transaction.
// ============================================================================
interface lpra_in_if;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [lpra_pkg::POS_W-1:0]    pack_position;
    logic [lpra_pkg::OFFSET_W-1:0] sector_offset;
    logic [lpra_pkg::SIZE_W-1:0]   size_sectors;
    logic                          discard_flag;

    modport source (
        output valid, op, pack_position, sector_offset, size_sectors, discard_flag,
        input  ready
    );

    modport sink (
        input  valid, op, pack_position, sector_offset, size_sectors, discard_flag,
        output ready
    );

endinterface

[hw/rtl/lpra_out_if.sv]
// ============================================================================
// Result channel
// Valid/ready channel that carries one allocation result per transaction.
// ============================================================================
interface lpra_out_if;

    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic                          has_record;
    logic                          rec_padding;
    logic                          rec_discard;
    logic [lpra_pkg::COUNT_W-1:0]  rec_index;
    logic [lpra_pkg::POS_W-1:0]    rec_position;
    logic [lpra_pkg::LOCAL_W-1:0]  rec_local;
    logic [lpra_pkg::OFFSET_W-1:0] rec_offset;
    logic [lpra_pkg::SIZE_W-1:0]   rec_size;
    logic [lpra_pkg::BLOCKS_W-1:0] total_blocks;
    logic [lpra_pkg::COUNT_W-1:0]  padding_count;
    logic                          last;

    modport source (
        output valid, accepted, has_record, rec_padding, rec_discard, rec_index,
               rec_position, rec_local, rec_offset, rec_size, total_blocks,
               padding_count, last,
        input  ready
    );

    modport sink (
        input  valid, accepted, has_record, rec_padding, rec_discard, rec_index,
               rec_position, rec_local, rec_offset, rec_size, total_blocks,
               padding_count, last,
        output ready
    );

endinterface

[hw/rtl/lpra_ctrl.sv]
// ============================================================================
// Log pack record allocator controller
// Sequences one request: decision, ring-modulo division, padding, emission.
// ============================================================================
module lpra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  lpra_pkg::status_t status,
    output lpra_pkg::cmd_t    cmd
);

    lpra_pkg::ctrl_state_t state_reg, state_next;
    lpra_pkg::res_kind_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpra_pkg::S_IDLE;
            kind_reg  <= lpra_pkg::RES_ACK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd           = '0;
        cmd.kind      = kind_reg;

        case (state_reg)
            lpra_pkg::S_IDLE:
            begin
                // ready is high here, so a valid request is a transaction
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                    state_next = lpra_pkg::S_DECIDE;
            end
            lpra_pkg::S_DECIDE:
            begin
                if (!status.op_add)
                begin
                    kind_next  = lpra_pkg::RES_BEGIN;
                    state_next = lpra_pkg::S_EMIT_LAST;
                end
                else if (status.table_full)
                begin
                    kind_next  = lpra_pkg::RES_REFUSE;
                    state_next = lpra_pkg::S_EMIT_LAST;
                end
                else if (status.size_zero)
                begin
                    kind_next  = lpra_pkg::RES_ACK;
                    state_next = lpra_pkg::S_EMIT_LAST;
                end
                else if (status.use_ring)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = lpra_pkg::S_DIV;
                end
                else
                begin
                    state_next = lpra_pkg::S_BUDGET;
                end
            end
            lpra_pkg::S_DIV:
            begin
                if (status.div_done)
                    state_next = lpra_pkg::S_PAD_CALC;
                else
                    cmd.div_step = 1'b1;
            end
            lpra_pkg::S_PAD_CALC:
            begin
                cmd.pad_load = 1'b1;
                state_next   = lpra_pkg::S_PAD_CHECK;
            end
            lpra_pkg::S_PAD_CHECK:
            begin
                if (status.pad_fits)
                begin
                    state_next = lpra_pkg::S_BUDGET;
                end
                else if (status.pad_over_budget)
                begin
                    kind_next  = lpra_pkg::RES_REFUSE;
                    state_next = lpra_pkg::S_EMIT_LAST;
                end
                else
                begin
                    state_next = lpra_pkg::S_EMIT_PAD;
                end
            end
            lpra_pkg::S_EMIT_PAD:
            begin
                cmd.kind = lpra_pkg::RES_PAD;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = lpra_pkg::S_BUDGET;
                end
            end
            lpra_pkg::S_BUDGET:
            begin
                // the table may have filled with the padding record
                if (status.table_full || status.rec_over_budget)
                    kind_next = lpra_pkg::RES_REFUSE;
                else
                    kind_next = lpra_pkg::RES_RECORD;
                state_next = lpra_pkg::S_EMIT_LAST;
            end
            lpra_pkg::S_EMIT_LAST:
            begin
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = lpra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lpra_datapath.sv]
// ============================================================================
// Log pack record allocator datapath
// Configuration and pack state, request capture, restoring divider for the
// ring modulo, and the result output register.
// ============================================================================
module lpra_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lpra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpra_pkg::CFG_DATA_W-1:0]   cfg_data,
    lpra_in_if.sink                           req,
    lpra_out_if.source                        rsp,
    input  lpra_pkg::cmd_t                    cmd,
    output lpra_pkg::status_t                 status
);

    // configuration
    logic [lpra_pkg::SHIFT_W-1:0]  block_shift_reg;
    logic [lpra_pkg::COUNT_W-1:0]  max_records_reg;
    logic [lpra_pkg::POS_W-1:0]    ring_size_reg;
    logic [lpra_pkg::BLOCKS_W-1:0] max_total_reg;

    // pack state
    logic [lpra_pkg::POS_W-1:0]    pack_start_reg, pack_start_next;
    logic [lpra_pkg::COUNT_W-1:0]  record_count_reg, record_count_next;
    logic [lpra_pkg::COUNT_W-1:0]  padding_total_reg, padding_total_next;
    logic [lpra_pkg::BLOCKS_W-1:0] blocks_used_reg, blocks_used_next;

    // captured request and working values
    logic                          op_reg;
    logic [lpra_pkg::POS_W-1:0]    new_start_reg;
    logic [lpra_pkg::OFFSET_W-1:0] offset_reg;
    logic [lpra_pkg::SIZE_W-1:0]   size_reg;
    logic                          disc_reg;
    logic [lpra_pkg::BPB_W-1:0]    bpb_reg;
    logic [lpra_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [lpra_pkg::POS_W-1:0]    pad_reg;

    // divider
    logic [lpra_pkg::POS_W-1:0]     dvd_reg;
    logic [lpra_pkg::POS_W-1:0]     rem_reg;
    logic [lpra_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [lpra_pkg::POS_W:0]       trial;
    logic [lpra_pkg::POS_W:0]       trial_diff;

    // output register
    logic out_valid_reg;
    logic out_acc_reg, out_has_reg, out_pad_reg, out_disc_reg, out_last_reg;
    logic [lpra_pkg::COUNT_W-1:0]  out_index_reg, out_pcount_reg;
    logic [lpra_pkg::POS_W-1:0]    out_pos_reg;
    logic [lpra_pkg::LOCAL_W-1:0]  out_local_reg;
    logic [lpra_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [lpra_pkg::SIZE_W-1:0]   out_size_reg;
    logic [lpra_pkg::BLOCKS_W-1:0] out_total_reg;

    logic                          in_fire;
    logic                          is_pad, is_rec, has_rec;
    logic [lpra_pkg::BPB_W-1:0]    size_mask;
    logic [lpra_pkg::BPB_W-1:0]    bpb_in;
    logic [lpra_pkg::POS_W-1:0]    pad_sum;
    logic [lpra_pkg::BPB_W:0]      rec_sum;
    logic [lpra_pkg::SIZE_W-1:0]   pad_size;
    logic [lpra_pkg::POS_W-1:0]    rel_pos;

    assign req.ready = cmd.in_ready;
    assign in_fire   = req.valid && req.ready;

    assign size_mask = (lpra_pkg::BPB_W'(1) << block_shift_reg) - lpra_pkg::BPB_W'(1);
    assign bpb_in    = ({1'b0, req.size_sectors} + size_mask) >> block_shift_reg;

    assign trial      = {rem_reg, dvd_reg[lpra_pkg::POS_W-1]};
    assign trial_diff = trial - {1'b0, ring_size_reg};

    assign pad_sum  = {{(lpra_pkg::POS_W-lpra_pkg::BLOCKS_W){1'b0}}, blocks_used_reg} + pad_reg;
    assign rec_sum  = {{(lpra_pkg::BPB_W+1-lpra_pkg::BLOCKS_W){1'b0}}, blocks_used_reg}
                    + {1'b0, bpb_reg};
    assign pad_size = pad_reg[lpra_pkg::SIZE_W-1:0] << block_shift_reg;
    assign rel_pos  = pos_reg - pack_start_reg;

    assign is_pad  = (cmd.kind == lpra_pkg::RES_PAD);
    assign is_rec  = (cmd.kind == lpra_pkg::RES_RECORD);
    assign has_rec = is_pad || is_rec;

    always_comb
    begin
        status.in_valid        = req.valid;
        status.op_add          = op_reg;
        status.table_full      = (record_count_reg >= max_records_reg);
        status.size_zero       = (size_reg == '0);
        status.use_ring        = !disc_reg && (ring_size_reg != '0);
        status.div_done        = (cnt_reg == '0);
        status.pad_fits        = !(pad_reg < {{(lpra_pkg::POS_W-lpra_pkg::BPB_W){1'b0}}, bpb_reg});
        status.pad_over_budget = (pad_sum >
                                  {{(lpra_pkg::POS_W-lpra_pkg::BLOCKS_W){1'b0}}, max_total_reg});
        status.rec_over_budget = !disc_reg && (rec_sum >
                                  {{(lpra_pkg::BPB_W+1-lpra_pkg::BLOCKS_W){1'b0}}, max_total_reg});
        status.out_free        = !out_valid_reg || rsp.ready;
    end

    // pack state updates on emission
    always_comb
    begin
        pack_start_next    = pack_start_reg;
        record_count_next  = record_count_reg;
        padding_total_next = padding_total_reg;
        blocks_used_next   = blocks_used_reg;
        pos_next           = pos_reg;
        if (cmd.emit)
        begin
            case (cmd.kind)
                lpra_pkg::RES_BEGIN:
                begin
                    pack_start_next    = new_start_reg;
                    record_count_next  = '0;
                    padding_total_next = '0;
                    blocks_used_next   = '0;
                end
                lpra_pkg::RES_PAD:
                begin
                    record_count_next  = record_count_reg + lpra_pkg::COUNT_W'(1);
                    padding_total_next = padding_total_reg + lpra_pkg::COUNT_W'(1);
                    blocks_used_next   = blocks_used_reg + pad_reg[lpra_pkg::BLOCKS_W-1:0];
                    pos_next           = pos_reg + pad_reg;
                end
                lpra_pkg::RES_RECORD:
                begin
                    record_count_next = record_count_reg + lpra_pkg::COUNT_W'(1);
                    if (!disc_reg)
                        blocks_used_next = blocks_used_reg + bpb_reg[lpra_pkg::BLOCKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            pos_next = pack_start_reg + lpra_pkg::POS_W'(1)
                     + {{(lpra_pkg::POS_W-lpra_pkg::BLOCKS_W){1'b0}}, blocks_used_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg   <= lpra_pkg::RST_BLOCK_SHIFT;
            max_records_reg   <= lpra_pkg::RST_MAX_RECORDS;
            ring_size_reg     <= lpra_pkg::RST_RING_SIZE_BLOCKS;
            max_total_reg     <= lpra_pkg::RST_MAX_TOTAL_BLOCKS;
            pack_start_reg    <= '0;
            record_count_reg  <= '0;
            padding_total_reg <= '0;
            blocks_used_reg   <= '0;
            out_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lpra_pkg::CFG_BLOCK_SHIFT:
                        block_shift_reg <= cfg_data[lpra_pkg::SHIFT_W-1:0];
                    lpra_pkg::CFG_MAX_RECORDS:
                        max_records_reg <= cfg_data[lpra_pkg::COUNT_W-1:0];
                    lpra_pkg::CFG_RING_SIZE_BLOCKS:
                        ring_size_reg <= cfg_data[lpra_pkg::POS_W-1:0];
                    lpra_pkg::CFG_MAX_TOTAL_BLOCKS:
                        max_total_reg <= cfg_data[lpra_pkg::BLOCKS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            pack_start_reg    <= pack_start_next;
            record_count_reg  <= record_count_next;
            padding_total_reg <= padding_total_next;
            blocks_used_reg   <= blocks_used_next;

            if (cmd.div_start)
                cnt_reg <= lpra_pkg::DIV_CNT_W'(lpra_pkg::POS_W);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - lpra_pkg::DIV_CNT_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (in_fire)
        begin
            op_reg        <= req.op;
            new_start_reg <= req.pack_position;
            offset_reg    <= req.sector_offset;
            size_reg      <= req.size_sectors;
            disc_reg      <= req.discard_flag;
            bpb_reg       <= bpb_in;
        end

        // restoring division, one quotient bit per cycle
        if (cmd.div_start)
        begin
            dvd_reg <= pos_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[lpra_pkg::POS_W-2:0], 1'b0};
            if (!trial_diff[lpra_pkg::POS_W])
                rem_reg <= trial_diff[lpra_pkg::POS_W-1:0];
            else
                rem_reg <= trial[lpra_pkg::POS_W-1:0];
        end

        if (cmd.pad_load)
            pad_reg <= ring_size_reg - rem_reg;

        if (cmd.emit)
        begin
            out_acc_reg    <= (cmd.kind != lpra_pkg::RES_REFUSE);
            out_has_reg    <= has_rec;
            out_pad_reg    <= is_pad;
            out_disc_reg   <= is_rec && disc_reg;
            out_index_reg  <= has_rec ? record_count_reg : '0;
            out_pos_reg    <= has_rec ? pos_reg : '0;
            out_local_reg  <= has_rec ? rel_pos[lpra_pkg::LOCAL_W-1:0] : '0;
            out_offset_reg <= is_rec ? offset_reg : '0;
            out_size_reg   <= is_pad ? pad_size : (is_rec ? size_reg : '0);
            out_total_reg  <= blocks_used_next;
            out_pcount_reg <= padding_total_next;
            out_last_reg   <= cmd.last;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.has_record    = out_has_reg;
    assign rsp.rec_padding   = out_pad_reg;
    assign rsp.rec_discard   = out_disc_reg;
    assign rsp.rec_index     = out_index_reg;
    assign rsp.rec_position  = out_pos_reg;
    assign rsp.rec_local     = out_local_reg;
    assign rsp.rec_offset    = out_offset_reg;
    assign rsp.rec_size      = out_size_reg;
    assign rsp.total_blocks  = out_total_reg;
    assign rsp.padding_count = out_pcount_reg;
    assign rsp.last          = out_last_reg;

endmodule

[hw/rtl/log_pack_record_allocator.sv]
// ============================================================================
// Log pack record allocator
// Assigns log positions to the records of one pack header of a ring-buffer
// write log and emits each record, with padding at the ring end.
// ============================================================================
// One request is handled at a time; a new request is taken as soon as the
// previous one has placed its last result in the output register, even if
// that result has not been taken yet. A begin, a request refused for a full
// table or a flush goes from the decision straight to its result; a discard,
// or a write on a zero ring, passes the budget check first. A write on a
// non-zero ring first takes the position modulo the ring size from a
// restoring divider that yields one quotient bit per cycle, followed by the
// pad compute and check, an optional padding emission and the budget check.
// A result that waits for a free output register stalls the sequence. Each
// request yields one or two results; the last one carries last = 1, and a
// padding record (last = 0) may precede a refusal or the record itself.
// Configuration writes take effect at once; the user must make them only
// while no request is in flight, as the block itself does not enforce this.
// ============================================================================
module log_pack_record_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpra_pkg::CFG_DATA_W-1:0] cfg_data,
    lpra_in_if.sink                         req,
    lpra_out_if.source                      rsp
);

    // commands from the controller, status back from the datapath
    lpra_pkg::cmd_t    cmd;
    lpra_pkg::status_t status;

    // sequence decision, division, padding and emission
    lpra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // hold configuration, pack counts, the divider and the result register
    lpra_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[tb/sv/tb_log_pack_record_allocator.sv]
// ============================================================================
// Log pack record allocator testbench
// Sends begin and add requests through the request channel and checks every
// result against an in-bench predictor of position, padding, refusal and the
// pack counts. Register settings change between phases while the block idles.
// ============================================================================
module tb_log_pack_record_allocator;

    import lpra_pkg::*;

    // Request operation codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    localparam int ITEM_TARGET = 1300;  // random requests to send in total
    localparam int QUIET_FROM  = 1150;  // no idling on either side from here on
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 100;   // longer than the slowest request
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                op;
        logic [POS_W-1:0]    pack_position;
        logic [OFFSET_W-1:0] sector_offset;
        logic [SIZE_W-1:0]   size_sectors;
        logic                discard_flag;
    } request_t;

    typedef struct packed {
        logic                accepted;
        logic                has_record;
        logic                rec_padding;
        logic                rec_discard;
        logic [COUNT_W-1:0]  rec_index;
        logic [POS_W-1:0]    rec_position;
        logic [LOCAL_W-1:0]  rec_local;
        logic [OFFSET_W-1:0] rec_offset;
        logic [SIZE_W-1:0]   rec_size;
        logic [BLOCKS_W-1:0] total_blocks;
        logic [COUNT_W-1:0]  padding_count;
        logic                last;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpra_in_if  req_if ();
    lpra_out_if rsp_if ();

    log_pack_record_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Register copies held by the predictor
    logic [SHIFT_W-1:0]  cur_shift;
    logic [COUNT_W-1:0]  cur_max_records;
    logic [POS_W-1:0]    cur_ring;
    logic [BLOCKS_W-1:0] cur_max_total;

    // Pack header state held by the predictor
    logic [POS_W-1:0]   hdr_start;
    logic [15:0]        hdr_records;
    logic [COUNT_W-1:0] hdr_pads;
    logic [63:0]        hdr_blocks;

    alloc_result_t awaited_results[$];

    logic idle_on;
    int   ready_hold;
    int   errors;
    int   items_sent;
    int   results_seen;
    int   pads_seen;
    int   refusals_seen;
    int   settings_used;
    int   cycle_count;

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        // Abort a hung run; the limit is several times the slowest clean run
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("tb_log_pack_record_allocator: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Build one result from the current pack state; record fields stay zero
    // when the result carries no record.
    function automatic alloc_result_t make_result(input logic acc, has, pad, disc,
                                                  input logic [63:0] pos, offs, size,
                                                  input logic last);
        alloc_result_t r;
        logic [63:0]   rel;
        r   = '0;
        rel = pos - hdr_start;
        r.accepted   = acc;
        r.has_record = has;
        if (has)
        begin
            r.rec_padding  = pad;
            r.rec_discard  = disc;
            r.rec_index    = hdr_records[COUNT_W-1:0];
            r.rec_position = pos;
            r.rec_local    = rel[LOCAL_W-1:0];
            r.rec_offset   = offs;
            r.rec_size     = size[SIZE_W-1:0];
        end
        r.total_blocks  = hdr_blocks[BLOCKS_W-1:0];
        r.padding_count = hdr_pads;
        r.last          = last;
        return r;
    endfunction

    // Work out the results of one accepted request and queue them in order.
    task automatic place_request(input request_t r);
        logic [63:0] pos;
        logic [63:0] mask;
        logic [63:0] bpb;
        logic [63:0] pad;
        logic        stop;
        begin
            stop = 1'b0;
            if (r.op == OP_BEGIN)
            begin
                hdr_start   = r.pack_position;
                hdr_records = '0;
                hdr_pads    = '0;
                hdr_blocks  = '0;
                awaited_results.push_back(make_result(1, 0, 0, 0, 0, 0, 0, 1));
            end
            else if (hdr_records >= {8'd0, cur_max_records})
            begin
                // Header full: refuse before anything else, flushes included
                awaited_results.push_back(make_result(0, 0, 0, 0, 0, 0, 0, 1));
            end
            else if (r.size_sectors == '0)
            begin
                // Flush: accept, no record
                awaited_results.push_back(make_result(1, 0, 0, 0, 0, 0, 0, 1));
            end
            else
            begin
                pos  = hdr_start + 64'd1 + hdr_blocks;
                mask = (64'd1 << cur_shift) - 64'd1;
                bpb  = ({32'd0, r.size_sectors} + mask) >> cur_shift;
                // Writes that cross the ring end get a padding record first
                if (!r.discard_flag && cur_ring != '0)
                begin
                    pad = cur_ring - (pos % cur_ring);
                    if (pad < bpb)
                    begin
                        if (hdr_blocks + pad > {48'd0, cur_max_total})
                        begin
                            awaited_results.push_back(make_result(0, 0, 0, 0, 0, 0, 0, 1));
                            stop = 1'b1;
                        end
                        else
                        begin
                            hdr_pads   = hdr_pads + 8'd1;
                            hdr_blocks = hdr_blocks + pad;
                            awaited_results.push_back(make_result(1, 1, 1, 0, pos, 0,
                                                                  pad << cur_shift, 0));
                            hdr_records = hdr_records + 16'd1;
                            pos         = pos + pad;
                            if (hdr_records >= {8'd0, cur_max_records})
                            begin
                                awaited_results.push_back(make_result(0, 0, 0, 0, 0, 0,
                                                                      0, 1));
                                stop = 1'b1;
                            end
                        end
                    end
                end
                if (!stop)
                begin
                    if (!r.discard_flag && hdr_blocks + bpb > {48'd0, cur_max_total})
                    begin
                        awaited_results.push_back(make_result(0, 0, 0, 0, 0, 0, 0, 1));
                    end
                    else
                    begin
                        if (!r.discard_flag)
                            hdr_blocks = hdr_blocks + bpb;
                        awaited_results.push_back(make_result(1, 1, 0, r.discard_flag, pos,
                                                              r.sector_offset,
                                                              {32'd0, r.size_sectors}, 1));
                        hdr_records = hdr_records + 16'd1;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------------

    // Drop ready for bursts of random length while idling is on.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold    <= ready_hold - 1;
            rsp_if.ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold    <= $urandom_range(0, 6);
            rsp_if.ready  <= 1'b0;
        end
        else
        begin
            rsp_if.ready  <= 1'b1;
        end
    end

    function automatic string show_result(input alloc_result_t r);
        return $sformatf({"acc=%0b rec=%0b pad=%0b disc=%0b idx=%0d pos=%h local=%h",
                          " off=%h size=%h blocks=%0d pads=%0d last=%0b"},
                         r.accepted, r.has_record, r.rec_padding, r.rec_discard,
                         r.rec_index, r.rec_position, r.rec_local, r.rec_offset,
                         r.rec_size, r.total_blocks, r.padding_count, r.last);
    endfunction

    // Compare each result transaction with the oldest awaited one.
    always @(posedge clk)
    begin : check_results
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.accepted      = rsp_if.accepted;
            got.has_record    = rsp_if.has_record;
            got.rec_padding   = rsp_if.rec_padding;
            got.rec_discard   = rsp_if.rec_discard;
            got.rec_index     = rsp_if.rec_index;
            got.rec_position  = rsp_if.rec_position;
            got.rec_local     = rsp_if.rec_local;
            got.rec_offset    = rsp_if.rec_offset;
            got.rec_size      = rsp_if.rec_size;
            got.total_blocks  = rsp_if.total_blocks;
            got.padding_count = rsp_if.padding_count;
            got.last          = rsp_if.last;
            results_seen = results_seen + 1;
            if (awaited_results.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("result with nothing awaited: %s", show_result(got));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.rec_padding)
                    pads_seen = pads_seen + 1;
                if (!want.accepted)
                    refusals_seen = refusals_seen + 1;
                if (got !== want)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("mismatch on result %0d", results_seen);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly small sizes, sometimes up to the block budget, rarely any 32 bits.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return $urandom_range(1, 65535);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // Send one request transaction; hold valid high across back-to-back items.
    task automatic send_request(input logic op, input logic [63:0] pos, off,
                                input logic [31:0] size, input logic disc);
        request_t r;
        begin
            r.op            = op;
            r.pack_position = pos;
            r.sector_offset = off;
            r.size_sectors  = size;
            r.discard_flag  = disc;
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            req_if.valid         <= 1'b1;
            req_if.op            <= op;
            req_if.pack_position <= pos;
            req_if.sector_offset <= off;
            req_if.size_sectors  <= size;
            req_if.discard_flag  <= disc;
            @(posedge clk);
            while (!req_if.ready) @(posedge clk);
            place_request(r);
            items_sent = items_sent + 1;
        end
    endtask

    // Drop valid and wait until every awaited result has been taken.
    task automatic wait_for_drain();
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while (awaited_results.size() != 0);
        end
    endtask

    // Write all four registers on back-to-back cycles while the block idles.
    task automatic set_registers(input logic [SHIFT_W-1:0] shift,
                                 input logic [COUNT_W-1:0] max_rec,
                                 input logic [POS_W-1:0] ring,
                                 input logic [BLOCKS_W-1:0] max_tot);
        begin
            wait_for_drain();
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_BLOCK_SHIFT;
            cfg_data  <= {{(CFG_DATA_W-SHIFT_W){1'b0}}, shift};
            @(posedge clk);
            cfg_index <= CFG_MAX_RECORDS;
            cfg_data  <= {{(CFG_DATA_W-COUNT_W){1'b0}}, max_rec};
            @(posedge clk);
            cfg_index <= CFG_RING_SIZE_BLOCKS;
            cfg_data  <= ring;
            @(posedge clk);
            cfg_index <= CFG_MAX_TOTAL_BLOCKS;
            cfg_data  <= {{(CFG_DATA_W-BLOCKS_W){1'b0}}, max_tot};
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            cur_shift       = shift;
            cur_max_records = max_rec;
            cur_ring        = ring;
            cur_max_total   = max_tot;
            settings_used   = settings_used + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: cross the end of the 65536-block ring, flush, discard.
    task automatic test_default_ring_crossing();
        begin
            send_request(OP_BEGIN, 64'd65530, '0, '0, 1'b0);
            // Lands 5 blocks before the ring end: padding, then the record
            send_request(OP_ADD, '0, '1, 32'd8, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd0, 1'b0);
            // Largest discard: never padded, no blocks used
            send_request(OP_ADD, '0, '0, '1, 1'b1);
            send_request(OP_ADD, '0, rand64(), 32'd0, 1'b1);
        end
    endtask

    // Record table limits: one slot, no slots, and padding that fills the table.
    task automatic test_table_limits();
        begin
            set_registers(2'd3, 8'd1, '1, 16'd65535);
            // Header at the top of the position space: the first record wraps
            send_request(OP_BEGIN, '1, '0, '0, 1'b0);
            send_request(OP_ADD, '0, rand64(), '1, 1'b0);
            send_request(OP_ADD, '0, '1, 32'd9, 1'b0);
            // Table now full: a flush is refused too
            send_request(OP_ADD, '0, '0, 32'd0, 1'b0);

            set_registers(2'd0, 8'd0, 64'd65536, 16'd65535);
            send_request(OP_BEGIN, '0, '0, '0, 1'b0);
            send_request(OP_ADD, '0, '0, 32'd0, 1'b0);

            // Ring of one block: a two-block write pads, padding fills the table
            set_registers(2'd0, 8'd1, 64'd1, 16'd65535);
            send_request(OP_BEGIN, 64'd100, '0, '0, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd2, 1'b0);
        end
    endtask

    // Block budget limits, a ring of size zero and the local position wrap.
    task automatic test_budget_limits();
        begin
            set_registers(2'd0, 8'd255, '0, 16'd65535);
            send_request(OP_BEGIN, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd65535, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd1, 1'b0);
            // Budget spent; a discard still fits, local position wraps to zero
            send_request(OP_ADD, '0, rand64(), 32'd5, 1'b1);

            // Padding that would blow the budget is refused outright
            set_registers(2'd0, 8'd255, 64'd16, 16'd3);
            send_request(OP_BEGIN, 64'd10, '0, '0, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd8, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd3, 1'b0);

            set_registers(2'd0, 8'd255, 64'd16, 16'd0);
            send_request(OP_BEGIN, '0, '0, '0, 1'b0);
            send_request(OP_ADD, '0, rand64(), 32'd1, 1'b0);
        end
    endtask

    // Random register settings, each followed by a few packs of mostly
    // well-formed traffic with flushes, discards and some odd requests mixed in.
    task automatic test_random_traffic();
        logic [SHIFT_W-1:0]  shift;
        logic [COUNT_W-1:0]  max_rec;
        logic [POS_W-1:0]    ring;
        logic [BLOCKS_W-1:0] max_tot;
        logic [POS_W-1:0]    start;
        int                  roll;
        begin
            while (items_sent < ITEM_TARGET)
            begin
                shift = SHIFT_W'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       max_rec = 8'd1;
                    1:       max_rec = 8'd255;
                    default: max_rec = COUNT_W'($urandom_range(2, 20));
                endcase
                case ($urandom_range(0, 7))
                    0:       ring = '0;
                    1:       ring = 64'd1;
                    2:       ring = '1;
                    3:       ring = rand64();
                    4, 5:    ring = POS_W'($urandom_range(2, 64));
                    default: ring = POS_W'($urandom_range(65, 5000));
                endcase
                case ($urandom_range(0, 4))
                    0:       max_tot = 16'd1;
                    1:       max_tot = 16'd65535;
                    default: max_tot = BLOCKS_W'($urandom_range(8, 2000));
                endcase
                set_registers(shift, max_rec, ring, max_tot);
                // Alternate stretches with and without idling
                idle_on <= (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);

                repeat ($urandom_range(2, 5))
                begin
                    // Open most packs just short of a ring boundary
                    if ($urandom_range(0, 3) == 0)
                        start = rand64();
                    else
                        start = ring * POS_W'($urandom_range(0, 5))
                              - POS_W'($urandom_range(0, 40));
                    send_request(OP_BEGIN, start, rand64(), $urandom,
                                 1'($urandom_range(0, 1)));

                    repeat ($urandom_range(1, 24))
                    begin
                        if (items_sent >= QUIET_FROM)
                            idle_on <= 1'b0;
                        roll = $urandom_range(0, 99);
                        if (roll < 8)
                            send_request(OP_ADD, rand64(), rand64(), 32'd0,
                                         1'($urandom_range(0, 1)));
                        else if (roll < 22)
                            send_request(OP_ADD, rand64(), rand64(), pick_size(), 1'b1);
                        else if (roll < 25)
                            send_request(OP_ADD, rand64(), rand64(), $urandom,
                                         1'($urandom_range(0, 1)));
                        else
                            send_request(OP_ADD, rand64(), rand64(), pick_size(), 1'b0);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before the first edge
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_BLOCK_SHIFT;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.op            = OP_BEGIN;
        req_if.pack_position = '0;
        req_if.sector_offset = '0;
        req_if.size_sectors  = '0;
        req_if.discard_flag  = 1'b0;
        rsp_if.ready         = 1'b0;
        idle_on              = 1'b1;
        ready_hold           = 0;
        errors               = 0;
        items_sent           = 0;
        results_seen         = 0;
        pads_seen            = 0;
        refusals_seen        = 0;
        settings_used        = 0;
        cycle_count          = 0;

        // Predictor starts from the reset values of state and registers
        cur_shift       = RST_BLOCK_SHIFT;
        cur_max_records = RST_MAX_RECORDS;
        cur_ring        = RST_RING_SIZE_BLOCKS;
        cur_max_total   = RST_MAX_TOTAL_BLOCKS;
        hdr_start       = '0;
        hdr_records     = '0;
        hdr_pads        = '0;
        hdr_blocks      = '0;

        // Hold reset, then release it on a rising edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_ring_crossing();
        test_table_limits();
        test_budget_limits();
        items_sent = 0;
        test_random_traffic();

        // Let the last results arrive, then give the block time to misbehave
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d random requests and the directed cases over %0d settings",
                 items_sent, settings_used);
        $display("checked %0d results: %0d padding records, %0d refusals, %0d errors",
                 results_seen, pads_seen, refusals_seen, errors);
        if (errors == 0)
        begin
            $display("tb_log_pack_record_allocator: clean");
        end
        else
        begin
            $display("tb_log_pack_record_allocator: errors");
        end
        $finish;
    end

endmodule
